// ===== sv/assert_macros.svh =====
// Assertion macros for the argument splitter.
// Standalone; modules include it by file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CLAS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CLAS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLAS_ASSERT(name, prop, msg)
`define CLAS_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ===== sv/clas_pkg.sv =====
// Shared types, constants and helpers for the argument splitter.
// No dependencies.
`timescale 1ns / 1ps
package clas_pkg;

  localparam int RUN_BITS   = 16;
  localparam int REP_W      = 16;
  localparam int CNT_W      = 16;
  localparam int RUN_EXT_W  = (RUN_BITS > REP_W) ? RUN_BITS : REP_W;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [REP_W-1:0] REP_MAX = {REP_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h5C;

  typedef struct packed {
    logic [7:0]       ch;
    logic [REP_W-1:0] rep;
    logic             arg_end;
    logic             line_end;
    logic [CNT_W-1:0] arg_total;
    logic             last;
  } res_t;

  typedef struct packed {
    res_t res0;
    res_t res1;
    logic two;
  } entry_t;

  function automatic logic [REP_W-1:0] sat_rep(input logic [RUN_BITS-1:0] v);
    logic [RUN_EXT_W-1:0] e;
    e = RUN_EXT_W'(v);
    if (e > RUN_EXT_W'(REP_MAX)) return REP_MAX;
    else return e[REP_W-1:0];
  endfunction

endpackage

// ===== sv/clas_front.sv =====
// Front end: accepts request bytes, tracks quoting state, builds result entries.
// Depends on clas_pkg.
`timescale 1ns / 1ps
module clas_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [7:0]             in_byte,
  output logic                   in_stall,
  input  logic                   q_full,
  output logic                   push,
  output clas_pkg::entry_t       push_entry
);

  logic                          in_arg_r, in_arg_nxt;
  logic                          quote_r, quote_nxt;
  logic                          pend_r, pend_nxt;
  logic [clas_pkg::RUN_BITS-1:0] run_r, run_nxt;
  logic [clas_pkg::CNT_W-1:0]    args_r, args_nxt;

  logic                          accept;
  logic                          q_eff;
  logic                          flush;
  logic [clas_pkg::RUN_BITS-1:0] half;
  logic [clas_pkg::CNT_W-1:0]    args_inc;
  logic [1:0]                    cnt;
  clas_pkg::res_t                r0, r1;
  clas_pkg::res_t                slash_res, char_res, blank_res;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign half     = run_r >> 1;
  assign flush    = (run_r != '0);
  assign args_inc = (args_r == clas_pkg::CNT_MAX) ? args_r : args_r + 1'b1;
  assign q_eff    = pend_r ? 1'b0 : quote_r;

  always_comb begin
    blank_res           = '0;
    blank_res.arg_total = args_r;
    slash_res           = blank_res;
    slash_res.ch        = clas_pkg::CH_SLASH;
    slash_res.rep       = clas_pkg::sat_rep(run_r);
    char_res            = blank_res;
    char_res.ch         = in_byte;
    char_res.rep        = clas_pkg::REP_W'(1);

    r0         = blank_res;
    r1         = blank_res;
    cnt        = 2'd0;
    in_arg_nxt = in_arg_r;
    quote_nxt  = quote_r;
    pend_nxt   = 1'b0;
    run_nxt    = run_r;
    args_nxt   = args_r;

    if (pend_r && in_byte == clas_pkg::CH_QUOTE) begin
      r0       = blank_res;
      r0.ch    = clas_pkg::CH_QUOTE;
      r0.rep   = clas_pkg::REP_W'(1);
      cnt      = 2'd1;
    end else begin
      quote_nxt = q_eff;
      if (in_byte == clas_pkg::CH_NUL) begin
        r0 = flush ? slash_res : blank_res;
        if (in_arg_r) begin
          r0.arg_end   = 1'b1;
          r0.arg_total = args_inc;
        end
        r0.line_end = 1'b1;
        cnt         = 2'd1;
        in_arg_nxt  = 1'b0;
        quote_nxt   = 1'b0;
        run_nxt     = '0;
        args_nxt    = '0;
      end else if (in_byte == clas_pkg::CH_SLASH) begin
        in_arg_nxt = 1'b1;
        if (run_r != {clas_pkg::RUN_BITS{1'b1}}) run_nxt = run_r + 1'b1;
      end else if (in_byte == clas_pkg::CH_QUOTE) begin
        in_arg_nxt = 1'b1;
        run_nxt    = '0;
        if (half != '0) begin
          r0     = blank_res;
          r0.ch  = clas_pkg::CH_SLASH;
          r0.rep = clas_pkg::sat_rep(half);
          if (run_r[0]) begin
            r1     = blank_res;
            r1.ch  = clas_pkg::CH_QUOTE;
            r1.rep = clas_pkg::REP_W'(1);
            cnt    = 2'd2;
          end else begin
            cnt = 2'd1;
          end
        end else if (run_r[0]) begin
          r0     = blank_res;
          r0.ch  = clas_pkg::CH_QUOTE;
          r0.rep = clas_pkg::REP_W'(1);
          cnt    = 2'd1;
        end
        if (!run_r[0]) begin
          if (q_eff) pend_nxt = 1'b1;
          else quote_nxt = 1'b1;
        end
      end else begin
        run_nxt = '0;
        if ((in_byte == clas_pkg::CH_SPACE || in_byte == clas_pkg::CH_TAB) && !q_eff) begin
          if (in_arg_r) begin
            r0           = flush ? slash_res : blank_res;
            r0.arg_end   = 1'b1;
            r0.arg_total = args_inc;
            args_nxt     = args_inc;
            in_arg_nxt   = 1'b0;
            cnt          = 2'd1;
          end else if (flush) begin
            r0  = slash_res;
            cnt = 2'd1;
          end
        end else begin
          in_arg_nxt = 1'b1;
          if (flush) begin
            r0  = slash_res;
            r1  = char_res;
            cnt = 2'd2;
          end else begin
            r0  = char_res;
            cnt = 2'd1;
          end
        end
      end
    end

    r0.last = (cnt == 2'd1);
    r1.last = 1'b1;
  end

  assign push            = accept && (cnt != 2'd0);
  assign push_entry.res0 = r0;
  assign push_entry.res1 = r1;
  assign push_entry.two  = (cnt == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_arg_r <= 1'b0;
      quote_r  <= 1'b0;
      pend_r   <= 1'b0;
      run_r    <= '0;
      args_r   <= '0;
    end else if (accept) begin
      in_arg_r <= in_arg_nxt;
      quote_r  <= quote_nxt;
      pend_r   <= pend_nxt;
      run_r    <= run_nxt;
      args_r   <= args_nxt;
    end
  end

endmodule

// ===== sv/clas_queue.sv =====
// Short entry queue between front and back ends.
// Depends on clas_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module clas_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  clas_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output clas_pkg::entry_t head,
  output logic             empty
);

  clas_pkg::entry_t              mem_r [clas_pkg::QDEPTH];
  logic [clas_pkg::QPTR_W-1:0]   wr_r, rd_r;
  logic [clas_pkg::QPTR_W:0]     cnt_r;

  assign full  = (cnt_r == (clas_pkg::QPTR_W+1)'(clas_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop) rd_r <= rd_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  `CLAS_ASSERT(a_no_overflow, (!(push && full)), "push into full queue")
  `CLAS_ASSERT(a_no_underflow, (!(pop && empty)), "pop from empty queue")
  `CLAS_ASSERT(a_cnt_bound, (cnt_r <= (clas_pkg::QPTR_W+1)'(clas_pkg::QDEPTH)), "queue count high")

endmodule

// ===== sv/clas_back.sv =====
// Back end: unpacks queue entries into single results behind an output register.
// Depends on clas_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module clas_back (
  input  logic             clk,
  input  logic             rst_n,
  input  clas_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  input  logic             out_stall,
  output logic             out_valid,
  output clas_pkg::res_t   out_res
);

  logic           out_valid_r;
  clas_pkg::res_t out_r;
  logic           sub_r;
  logic           load;

  assign load      = !out_valid_r || !out_stall;
  assign pop       = load && !empty && (sub_r || !head.two);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_ff @(posedge clk) begin
    if (load && !empty) out_r <= sub_r ? head.res1 : head.res0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= 1'b0;
    end else if (load) begin
      out_valid_r <= !empty;
      if (!empty) sub_r <= !sub_r && head.two;
    end
  end

  `CLAS_ASSERT(a_sub_has_entry, (sub_r |-> (!empty && head.two)), "second half without entry")
  `CLAS_ASSERT(a_line_end_last, (out_valid_r && out_r.line_end |-> out_r.last), "line end not last")
  `CLAS_ASSERT(a_first_not_last, (out_valid_r && sub_r |-> !out_r.last), "first of pair marked last")

endmodule

// ===== sv/command_line_argument_splitter_unit.sv =====
// Command-line argument splitter. Takes one command-line byte per cycle
// (a zero byte ends the line) and returns the characters of each argument,
// backslash runs as one result with a repeat count, with argument and line
// end flags and a running argument count. The front end accepts one byte
// every cycle while its 4-entry queue has room; a byte gives zero, one or
// two results, and the back end sends at most one result per cycle from its
// output register, so bytes that give two results (an odd backslash run of
// three or more before a quote, or a backslash run before an ordinary
// character) send them one after the other, which the queue absorbs.
// Depends on clas_pkg, clas_front, clas_queue, clas_back.
`timescale 1ns / 1ps
module command_line_argument_splitter_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [7:0]                   in_byte,
  output logic                         in_stall,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte,
  output logic [clas_pkg::REP_W-1:0]   out_repeat_res,
  output logic                         out_arg_end,
  output logic                         out_line_end,
  output logic [clas_pkg::CNT_W-1:0]   out_arg_total,
  output logic                         out_last
);

  logic             push, full, pop, empty;
  clas_pkg::entry_t push_entry, head;
  clas_pkg::res_t   res;

  clas_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .in_stall   (in_stall),
    .q_full     (full),
    .push       (push),
    .push_entry (push_entry)
  );

  clas_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  clas_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_byte       = res.ch;
  assign out_repeat_res = res.rep;
  assign out_arg_end    = res.arg_end;
  assign out_line_end   = res.line_end;
  assign out_arg_total  = res.arg_total;
  assign out_last       = res.last;

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for command_line_argument_splitter_unit: a queue of command-line bytes
// feeds a valid/stall driver, each accepted byte is split in a local model of the quoting rules,
// and the monitor compares every result field. Depends on clas_pkg and the unit itself.
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic [7:0]                 ch;
    logic [clas_pkg::REP_W-1:0] rep;
    logic                       arg_end;
    logic                       line_end;
    logic [clas_pkg::CNT_W-1:0] total;
    logic                       last;
  } arg_piece_t;

  localparam int QUIET_LIMIT    = 1000;
  localparam int SQUEEZE_CYCLES = 150;
  localparam int RANDOM_BYTES   = 126;
  localparam int CALM_BYTES     = 40;
  localparam logic [clas_pkg::RUN_BITS-1:0] RUN_TOP = '1;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic [7:0]                 in_byte = 8'h00;
  logic                       in_stall;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [7:0]                 out_byte;
  logic [clas_pkg::REP_W-1:0] out_repeat_res;
  logic                       out_arg_end;
  logic                       out_line_end;
  logic [clas_pkg::CNT_W-1:0] out_arg_total;
  logic                       out_last;

  logic [7:0] cmd_bytes[$];
  arg_piece_t expected_pieces[$];
  arg_piece_t piece_buf[3];
  int         piece_n;

  logic                          arg_open = 1'b0;
  logic                          quoted = 1'b0;
  logic                          close_wait = 1'b0;
  logic [clas_pkg::RUN_BITS-1:0] bs_run = '0;
  logic [clas_pkg::CNT_W-1:0]    args_seen = '0;

  int bytes_taken = 0;
  int total_bytes = 0;
  int calm_from = 0;
  int squeeze_at = 0;
  int mismatches = 0;
  int quiet = 0;
  int send_gap = 0;
  int hold_left = 0;
  bit squeezed = 1'b0;
  bit in_took = 1'b0;

  command_line_argument_splitter_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_byte        (in_byte),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_repeat_res (out_repeat_res),
    .out_arg_end    (out_arg_end),
    .out_line_end   (out_line_end),
    .out_arg_total  (out_arg_total),
    .out_last       (out_last)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic void add_piece(input logic [7:0] ch,
                                    input logic [clas_pkg::RUN_BITS-1:0] n);
    longint unsigned reps;
    arg_piece_t p;
    reps = n;
    if (reps > clas_pkg::REP_MAX) reps = clas_pkg::REP_MAX;
    p = '0;
    p.rep = reps[clas_pkg::REP_W-1:0];
    p.ch = (reps == 0) ? clas_pkg::CH_NUL : ch;
    p.total = args_seen;
    piece_buf[piece_n] = p;
    piece_n++;
  endfunction

  function automatic void flush_run();
    if (bs_run != 0) begin
      add_piece(clas_pkg::CH_SLASH, bs_run);
      bs_run = '0;
    end
  endfunction

  function automatic void close_arg();
    if (args_seen != clas_pkg::CNT_MAX) args_seen++;
    arg_open = 1'b0;
    if (piece_n == 0) add_piece(clas_pkg::CH_NUL, '0);
    piece_buf[piece_n-1].arg_end = 1'b1;
    piece_buf[piece_n-1].total = args_seen;
  endfunction

  function automatic void split_byte(input logic [7:0] b);
    logic [clas_pkg::RUN_BITS-1:0] half;
    piece_n = 0;
    half = bs_run >> 1;
    if (close_wait && b == clas_pkg::CH_QUOTE) begin
      close_wait = 1'b0;
      add_piece(clas_pkg::CH_QUOTE, clas_pkg::RUN_BITS'(1));
    end else begin
      if (close_wait) begin
        close_wait = 1'b0;
        quoted = 1'b0;
      end
      if (b == clas_pkg::CH_NUL) begin
        flush_run();
        if (arg_open) close_arg();
        if (piece_n == 0) add_piece(clas_pkg::CH_NUL, '0);
        piece_buf[piece_n-1].line_end = 1'b1;
        arg_open = 1'b0;
        quoted = 1'b0;
        bs_run = '0;
        args_seen = '0;
      end else if (b == clas_pkg::CH_SLASH) begin
        arg_open = 1'b1;
        if (bs_run != RUN_TOP) bs_run++;
      end else if (b == clas_pkg::CH_QUOTE) begin
        arg_open = 1'b1;
        if (half != 0) add_piece(clas_pkg::CH_SLASH, half);
        if (bs_run[0]) add_piece(clas_pkg::CH_QUOTE, clas_pkg::RUN_BITS'(1));
        else if (quoted) close_wait = 1'b1;
        else quoted = 1'b1;
        bs_run = '0;
      end else begin
        flush_run();
        if ((b == clas_pkg::CH_SPACE || b == clas_pkg::CH_TAB) && !quoted) begin
          if (arg_open) close_arg();
        end else begin
          arg_open = 1'b1;
          add_piece(b, clas_pkg::RUN_BITS'(1));
        end
      end
    end
    if (piece_n > 0) piece_buf[piece_n-1].last = 1'b1;
    for (int i = 0; i < piece_n; i++) expected_pieces.push_back(piece_buf[i]);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) cmd_bytes.push_back(s[i]);
  endtask

  // request side: accept at the rising edge, drive at the falling edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      split_byte(in_byte);
      void'(cmd_bytes.pop_front());
      bytes_taken++;
      in_took = 1'b1;
    end else begin
      in_took = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (cmd_bytes.size() == 0) begin
        in_valid <= 1'b0;
      end else if (bytes_taken < calm_from && $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(0, 16);
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_byte <= cmd_bytes[0];
      end
    end
  end

  // result side: hold off in bursts, once for a long stretch
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!squeezed && bytes_taken >= squeeze_at) begin
      squeezed = 1'b1;
      hold_left = SQUEEZE_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (bytes_taken < calm_from && $urandom_range(0, 15) == 0) begin
      hold_left = $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    arg_piece_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pieces.size() == 0) begin
        $error("out_byte: expected no result, actual %0d", out_byte);
        mismatches++;
      end else begin
        want = expected_pieces.pop_front();
        check_field("out_byte", want.ch, out_byte);
        check_field("out_repeat_res", want.rep, out_repeat_res);
        check_field("out_arg_end", want.arg_end, out_arg_end);
        check_field("out_line_end", want.line_end, out_line_end);
        check_field("out_arg_total", want.total, out_arg_total);
        check_field("out_last", want.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int k;
    int n;
    int rnd_start;
    // separators, empty quotes, odd backslash run before a quote
    push_text(" \t\"\" a\\\\\\\"b ");
    cmd_bytes.push_back(clas_pkg::CH_NUL);
    // doubled quote inside quotes, top byte, even run closing quotes, line end on pending close
    push_text("\"x\"\"y");
    cmd_bytes.push_back(8'hFF);
    push_text("\\\\\"");
    cmd_bytes.push_back(clas_pkg::CH_NUL);
    // runs flushed by a plain byte and by the line end
    push_text("a\\\\");
    cmd_bytes.push_back(8'h01);
    push_text("\\");
    cmd_bytes.push_back(clas_pkg::CH_NUL);
    cmd_bytes.push_back(clas_pkg::CH_NUL);
    // unterminated quote
    push_text("\"q");
    cmd_bytes.push_back(clas_pkg::CH_NUL);

    rnd_start = cmd_bytes.size();
    while (cmd_bytes.size() < rnd_start + RANDOM_BYTES) begin
      k = $urandom_range(0, 10);
      case (k)
        0, 1, 2: cmd_bytes.push_back(8'($urandom_range(33, 126)));
        3: cmd_bytes.push_back($urandom_range(0, 1) ? clas_pkg::CH_SPACE : clas_pkg::CH_TAB);
        4: cmd_bytes.push_back(clas_pkg::CH_QUOTE);
        5: begin
          n = $urandom_range(1, 5);
          repeat (n) cmd_bytes.push_back(clas_pkg::CH_SLASH);
          cmd_bytes.push_back(clas_pkg::CH_QUOTE);
        end
        6: begin
          n = $urandom_range(1, 4);
          repeat (n) cmd_bytes.push_back(clas_pkg::CH_SLASH);
          cmd_bytes.push_back(8'($urandom_range(97, 122)));
        end
        7: begin
          cmd_bytes.push_back(clas_pkg::CH_QUOTE);
          cmd_bytes.push_back(clas_pkg::CH_QUOTE);
        end
        8, 9: cmd_bytes.push_back(8'($urandom_range(1, 255)));
        default: cmd_bytes.push_back(clas_pkg::CH_NUL);
      endcase
    end
    cmd_bytes.push_back(clas_pkg::CH_NUL);
    total_bytes = cmd_bytes.size();
    calm_from = total_bytes - CALM_BYTES;
    squeeze_at = rnd_start + 30;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (bytes_taken < total_bytes) @(negedge clk);
    while (expected_pieces.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
